### rtl/rdc_pkg.sv
// Shared types, constants and the digit-to-character function of the radix digit converter.
`default_nettype none
package rdc_pkg;

   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 6'd10;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CH_ALPHA = 7'd65;

   typedef struct packed {
      logic               clear;
      logic               shift;
      logic [DIGIT_W-1:0] radix;
   } cell_ctl_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] r;
      if (d < DEC_LIMIT) begin
         r = CH_ZERO + {1'b0, d};
      end else begin
         r = CH_ALPHA + {1'b0, d} - {1'b0, DEC_LIMIT};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/rdc_cell.sv
// One digit cell: doubles its digit and adds the carry from below, or shifts digits upward.
`default_nettype none
module rdc_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rdc_pkg::cell_ctl_type        ctl,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]  prev_digit,
   input  wire logic                         prev_step,
   input  wire logic                         prev_carry,
   output logic      [rdc_pkg::DIGIT_W-1:0]  digit,
   output logic                              step,
   output logic                              carry
);
   import rdc_pkg::*;

   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               step_ff;
   logic               carry_ff, carry_in;
   logic [DIGIT_W:0]   dbl;
   logic [DIGIT_W:0]   diff;

   always_comb begin
      dbl  = {digit_ff, prev_carry};
      diff = dbl - {1'b0, ctl.radix};
      if (dbl >= {1'b0, ctl.radix}) begin
         carry_in = 1'b1;
         digit_in = diff[DIGIT_W-1:0];
      end else begin
         carry_in = 1'b0;
         digit_in = dbl[DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 1'b0;
         carry_ff <= 1'b0;
      end else begin
         step_ff  <= prev_step;
         carry_ff <= prev_step & carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         digit_ff <= '0;
      end else if (prev_step) begin
         digit_ff <= digit_in;
      end else if (ctl.shift) begin
         digit_ff <= prev_digit;
      end
   end

   assign digit = digit_ff;
   assign step  = step_ff;
   assign carry = carry_ff;

endmodule
`default_nettype wire

### rtl/rdc_ctrl.sv
// Sequencer of the converter: radix register, bit feed into the cell row and digit emission.
`default_nettype none
module rdc_ctrl #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [VALUE_BITS-1:0]        req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [rdc_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                              rsp_last_digit,
   input  wire logic                         csr_we,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]  csr_wdata,
   output rdc_pkg::cell_ctl_type             ctl,
   output logic                              feed_bit,
   output logic                              feed_step,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]  top_digit,
   input  wire logic                         top_step,
   input  wire logic                         top_carry
);
   import rdc_pkg::*;

   localparam int CNT_W = $clog2(VALUE_BITS + MAX_DIGITS);
   localparam int REM_W = $clog2(MAX_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(VALUE_BITS + MAX_DIGITS - 1);
   localparam logic [CNT_W-1:0] CNT_FEED  = CNT_W'(VALUE_BITS);
   localparam logic [REM_W-1:0] REM_FULL  = REM_W'(MAX_DIGITS);
   localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

   typedef enum logic [1:0] {ST_IDLE, ST_CONVERT, ST_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [DIGIT_W-1:0] radix_ff, radix_in;
   logic [DIGIT_W-1:0] radix_eff_ff, radix_eff_in;
   logic [VALUE_BITS-1:0] shreg_ff, shreg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               ovf_ff, ovf_in;
   logic               lead_ff, lead_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic               accept;
   logic               advance;
   logic               skip;
   logic               ovf_now;

   always_comb begin
      accept  = req_valid && (state_ff == ST_IDLE);
      advance = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
      skip    = lead_ff && (top_digit == '0) && (rem_ff != REM_ONE);
      ovf_now = ovf_ff | (top_step & top_carry);

      state_in     = state_ff;
      radix_in     = csr_we ? csr_wdata : radix_ff;
      radix_eff_in = radix_eff_ff;
      shreg_in     = shreg_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      ovf_in       = ovf_ff;
      lead_in      = lead_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      char_in      = char_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONVERT;
               shreg_in = req_value;
               cnt_in   = '0;
               ovf_in   = 1'b0;
               if (radix_ff < RADIX_MIN) begin
                  radix_eff_in = RADIX_MIN;
               end else if (radix_ff > RADIX_MAX) begin
                  radix_eff_in = RADIX_MAX;
               end else begin
                  radix_eff_in = radix_ff;
               end
            end
         end
         ST_CONVERT: begin
            shreg_in = {shreg_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in   = cnt_ff + CNT_W'(1);
            ovf_in   = ovf_now;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_EMIT;
               rem_in   = REM_FULL;
               lead_in  = !ovf_now;
            end
         end
         ST_EMIT: begin
            if (advance) begin
               rem_in = rem_ff - REM_ONE;
               if (!skip) begin
                  rsp_valid_in = 1'b1;
                  char_in      = digit_to_ascii(top_digit);
                  last_in      = (rem_ff == REM_ONE);
                  lead_in      = 1'b0;
               end
               if (rem_ff == REM_ONE) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         ovf_ff       <= 1'b0;
         lead_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         ovf_ff       <= ovf_in;
         lead_ff      <= lead_in;
         radix_eff_ff <= radix_eff_in;
         shreg_ff     <= shreg_in;
         char_ff      <= char_in;
         last_ff      <= last_in;
      end
   end

   always_comb begin
      ctl.clear = accept;
      ctl.shift = advance;
      ctl.radix = radix_eff_ff;
   end

   assign feed_step      = (state_ff == ST_CONVERT) && (cnt_ff < CNT_FEED);
   assign feed_bit       = shreg_ff[VALUE_BITS-1];
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule
`default_nettype wire

### rtl/radix_digit_converter_top.sv
// Top level of the radix digit converter: sequencer and the row of digit cells.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_value
//   rsp       out        rsp_valid/rsp_ready    rsp_digit_char, rsp_last_digit
//   csr       in         csr_we                 csr_wdata (radix)
//
// Once a transfer is accepted, the value's bits and their carries ripple as a wave through
// the cell row, then the stored digits are emitted from the top cell, leading zeros dropped
// (the last digit is always emitted, and zeros are kept after an overflow).
// Reset clears the sequencer, the radix register (to ten) and the output valid.
// A stalled rsp transfer holds the digit emission; req is taken only between conversions.
`default_nettype none
module radix_digit_converter_top #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [VALUE_BITS-1:0]        req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [rdc_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                              rsp_last_digit,
   input  wire logic                         csr_we,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]  csr_wdata
);
   import rdc_pkg::*;

   cell_ctl_type       ctl;
   logic               feed_bit;
   logic               feed_step;
   logic [DIGIT_W-1:0] digit_w [MAX_DIGITS];
   logic               step_w  [MAX_DIGITS];
   logic               carry_w [MAX_DIGITS];

   rdc_ctrl #(
      .VALUE_BITS(VALUE_BITS),
      .MAX_DIGITS(MAX_DIGITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last_digit(rsp_last_digit),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .ctl           (ctl),
      .feed_bit      (feed_bit),
      .feed_step     (feed_step),
      .top_digit     (digit_w[MAX_DIGITS-1]),
      .top_step      (step_w[MAX_DIGITS-1]),
      .top_carry     (carry_w[MAX_DIGITS-1])
   );

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         rdc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .prev_digit('0),
            .prev_step (feed_step),
            .prev_carry(feed_bit),
            .digit     (digit_w[i]),
            .step      (step_w[i]),
            .carry     (carry_w[i])
         );
      end else begin : g_rest
         rdc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .prev_digit(digit_w[i-1]),
            .prev_step (step_w[i-1]),
            .prev_carry(carry_w[i-1]),
            .digit     (digit_w[i]),
            .step      (step_w[i]),
            .carry     (carry_w[i])
         );
      end
   end

endmodule
`default_nettype wire
